// ----- sv/eptc_pkg.sv -----
// ----------------------------------------------------------------------------
// eptc_pkg
// Constants, tables and types for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package eptc_pkg;

  localparam int unsigned SecondsBitsDefault = 32;

  // 86400 = 2^7 * 675; the power of two is peeled off as a shift
  localparam int unsigned DayOddFactor   = 675;
  localparam int unsigned SecsPerHour    = 3600;
  localparam int unsigned SecsPerMinute  = 60;

  // Dates are counted from 1601-01-01, the start of a 400 year cycle
  localparam int unsigned YearBase       = 1601;
  localparam int unsigned Days1601To1970 = 134774;
  localparam int unsigned DaysPer400     = 146097;
  localparam int unsigned DaysPer100     = 36524;
  localparam int unsigned DaysPer4       = 1461;
  localparam int unsigned DaysPerYear    = 365;

  // 1970-01-01 was a Thursday
  localparam int unsigned EpochWeekday   = 4;

  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // first zero-based day of the year that falls in the given month
  function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
    logic [8:0] base;
    base = MonthStart[month];
    return base + ((leap && (month >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

  // result fields, filled in as the item moves down the pipeline
  typedef struct packed {
    logic [11:0] year;
    logic [8:0]  doy;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        leap;
    logic        cent3;   // fourth century of the 400 year cycle
    logic        quad24;  // last four-year block of the century
  } cal_t;

endpackage

// ----- sv/epoch_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 UTC into time of day and Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries one timestamp per item in
//   epoch_seconds_i (SECONDS_BITS wide, unsigned). Output channel
//   out_valid_o / out_ready_i carries second, minute, hour, year (mod 4096),
//   zero-based day of year and month, one-based day of month and weekday
//   (0 = Sunday). Every input item gives exactly one output item, in order.
// Throughput:
//   One item per cycle sustained unless out_ready_i stalls the output:
//   a fifteen stage pipeline of constant reciprocal multiplies, each followed
//   by a remainder stage and a single compare-and-correct stage.
// Reset:
//   rst_ni clears all stage valid bits; the pipeline comes up empty and ready.
// Stall:
//   While an output item waits and out_ready_i is low, the whole pipeline
//   holds and in_ready_o is low; nothing is dropped or repeated. Empty stages
//   are not squeezed out.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
  parameter int unsigned SECONDS_BITS = eptc_pkg::SecondsBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SECONDS_BITS-1:0] epoch_seconds_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [5:0]              second_o,
  output logic [5:0]              minute_o,
  output logic [4:0]              hour_o,
  output logic [11:0]             year_o,
  output logic [8:0]              day_of_year_o,
  output logic [3:0]              month_index_o,
  output logic [4:0]              day_of_month_o,
  output logic [2:0]              weekday_o
);
  import eptc_pkg::*;

  localparam int unsigned NumStages = 15;
  localparam int unsigned XW  = SECONDS_BITS - 7;          // seconds >> 7
  localparam int unsigned DW  = XW - 9;                    // whole days
  localparam int unsigned PRW = XW + DW;
  localparam int unsigned PW  = ((DW > 17) ? DW : 17) + 1; // days since 1601
  localparam int unsigned NW  = PW - 17;                   // 400 year cycles
  localparam int unsigned CW  = PW + NW;
  localparam int unsigned G   = (DW + 3) / 3;              // octal digits

  localparam logic [DW-1:0] RecipDay   = DW'((64'd1 << XW) / DayOddFactor);
  localparam logic [NW-1:0] RecipCycle = NW'((64'd1 << PW) / DaysPer400);
  localparam logic [5:0]    RecipHour  = 6'((1 << 17) / SecsPerHour);
  localparam logic [6:0]    RecipMin   = 7'((1 << 12) / SecsPerMinute);
  localparam logic [5:0]    RecipQuad  = 6'((1 << 16) / DaysPer4);

  logic                 adv;
  logic [NumStages-1:0] vld_q;
  cal_t                 res_q [NumStages];
  cal_t                 res_d [NumStages];

  logic [XW-1:0]  s1_x_q, s2_x_q;
  logic [6:0]     s1_lo_q, s2_lo_q, s3_lo_q;
  logic [PRW-1:0] s2_prod_q;
  logic [DW-1:0]  s3_day_q, s4_day_q;
  logic [10:0]    s3_rem_q;
  logic [16:0]    s4_tod_q, s5_tod_q;
  logic [PW-1:0]  s5_dp_q, s6_dp_q;
  logic [22:0]    s5_hprod_q;
  logic [CW-1:0]  s6_cprod_q;
  logic [5:0]     s6_hest_q;
  logic [12:0]    s6_rh_q;
  logic [NW-1:0]  s7_n400_q;
  logic [18:0]    s7_r400_q;
  logic [11:0]    s7_rh_q;
  logic [17:0]    s8_r400_q;
  logic [18:0]    s8_mprod_q;
  logic [6:0]     s8_rhlo_q;
  logic [15:0]    s9_r100_q, s10_r100_q;
  logic [6:0]     s9_mest_q, s9_sraw_q;
  logic [21:0]    s10_prod4_q;
  logic [5:0]     s11_n4_q;
  logic [11:0]    s11_r4_q;
  logic [10:0]    s12_r4_q;

  logic [DW-1:0]  day_est_d;
  logic [10:0]    rem_raw_d, rem_fix_d;
  logic           day_fix_d;
  logic [DW:0]    wd_in_d;
  logic [3*G-1:0] wd_pad_d;
  logic [5:0]     wd_sum_d;
  logic [3:0]     wd_fold_d;
  logic [2:0]     wd_d;
  logic [5:0]     hest_d;
  logic           hfix_d;
  logic [NW-1:0]  nest_d, n400_d;
  logic           cfix_d;
  logic [17:0]    r400_d;
  logic [6:0]     mest_d;
  logic           sfix_d;
  logic           ge1_d, ge2_d, ge3_d;
  logic [1:0]     n100_d;
  logic [15:0]    r100_d;
  logic [5:0]     n4est_d, n4_d;
  logic           qfix_d;
  logic           yge1_d, yge2_d, yge3_d;
  logic [1:0]     n1_d;
  logic [10:0]    doy_full_d;
  logic [3:0]     month_d;

  assign adv        = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    // whole days and the remainder of seconds >> 7 by 675
    day_est_d = s2_prod_q[PRW-1:XW];
    rem_raw_d = s2_x_q[10:0] - day_est_d[10:0] * 11'(DayOddFactor);
    day_fix_d = s3_rem_q >= 11'(DayOddFactor);
    rem_fix_d = day_fix_d ? s3_rem_q - 11'(DayOddFactor) : s3_rem_q;

    // weekday: 8 = 1 mod 7, so fold octal digits
    wd_in_d  = (DW+1)'(s4_day_q) + (DW+1)'(EpochWeekday);
    wd_pad_d = (3*G)'(wd_in_d);
    wd_sum_d = '0;
    for (int g = 0; g < G; g++) begin
      wd_sum_d = wd_sum_d + 6'(wd_pad_d[3*g +: 3]);
    end
    wd_fold_d = 4'(wd_sum_d[5:3]) + 4'(wd_sum_d[2:0]);
    if (wd_fold_d >= 4'd14) begin
      wd_d = 3'(wd_fold_d - 4'd14);
    end else if (wd_fold_d >= 4'd7) begin
      wd_d = 3'(wd_fold_d - 4'd7);
    end else begin
      wd_d = 3'(wd_fold_d);
    end

    hest_d = s5_hprod_q[22:17];
    hfix_d = s6_rh_q >= 13'(SecsPerHour);

    nest_d = s6_cprod_q[CW-1:PW];
    cfix_d = s7_r400_q >= 19'(DaysPer400);
    n400_d = s7_n400_q + NW'(cfix_d);
    r400_d = 18'(cfix_d ? s7_r400_q - 19'(DaysPer400) : s7_r400_q);

    mest_d = s8_mprod_q[18:12];
    sfix_d = s9_sraw_q >= 7'(SecsPerMinute);

    // century within the cycle; the last century gets the extra day
    ge1_d  = s8_r400_q >= 18'(DaysPer100);
    ge2_d  = s8_r400_q >= 18'(2 * DaysPer100);
    ge3_d  = s8_r400_q >= 18'(3 * DaysPer100);
    n100_d = 2'(ge1_d) + 2'(ge2_d) + 2'(ge3_d);
    if (ge3_d) begin
      r100_d = 16'(s8_r400_q - 18'(3 * DaysPer100));
    end else if (ge2_d) begin
      r100_d = 16'(s8_r400_q - 18'(2 * DaysPer100));
    end else if (ge1_d) begin
      r100_d = 16'(s8_r400_q - 18'(DaysPer100));
    end else begin
      r100_d = 16'(s8_r400_q);
    end

    n4est_d = s10_prod4_q[21:16];
    qfix_d  = s11_r4_q >= 12'(DaysPer4);
    n4_d    = s11_n4_q + 6'(qfix_d);

    yge1_d = s12_r4_q >= 11'(DaysPerYear);
    yge2_d = s12_r4_q >= 11'(2 * DaysPerYear);
    yge3_d = s12_r4_q >= 11'(3 * DaysPerYear);
    n1_d   = 2'(yge1_d) + 2'(yge2_d) + 2'(yge3_d);
    doy_full_d = s12_r4_q - 11'(n1_d) * 11'(DaysPerYear);

    month_d = '0;
    for (int m = 1; m < 12; m++) begin
      month_d = month_d + 4'(res_q[12].doy >= month_start(4'(m), res_q[12].leap));
    end

    res_d[0] = '0;
    for (int k = 1; k < NumStages; k++) begin
      res_d[k] = res_q[k-1];
    end
    res_d[4].weekday = wd_d;
    res_d[6].hour    = 5'(s6_hest_q + 6'(hfix_d));
    res_d[7].year    = 12'(YearBase) + 12'(n400_d) * 12'd400;
    res_d[8].year    = res_q[7].year + 12'(n100_d) * 12'd100;
    res_d[8].cent3   = ge3_d;
    res_d[9].minute  = 6'(s9_mest_q + 7'(sfix_d));
    res_d[9].second  = 6'(sfix_d ? s9_sraw_q - 7'(SecsPerMinute) : s9_sraw_q);
    res_d[11].year   = res_q[10].year + 12'(n4_d) * 12'd4;
    res_d[11].quad24 = n4_d == 6'd24;
    res_d[12].year   = res_q[11].year + 12'(n1_d);
    res_d[12].doy    = 9'(doy_full_d);
    res_d[12].leap   = (n1_d == 2'd3) && (!res_q[11].quad24 || res_q[11].cent3);
    res_d[13].month  = month_d;
    res_d[14].dom    = 5'(res_q[13].doy - month_start(res_q[13].month, res_q[13].leap)
                          + 9'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q       <= res_d;
      s1_x_q      <= epoch_seconds_i[SECONDS_BITS-1:7];
      s1_lo_q     <= epoch_seconds_i[6:0];
      s2_prod_q   <= PRW'(s1_x_q) * PRW'(RecipDay);
      s2_x_q      <= s1_x_q;
      s2_lo_q     <= s1_lo_q;
      s3_day_q    <= day_est_d;
      s3_rem_q    <= rem_raw_d;
      s3_lo_q     <= s2_lo_q;
      s4_day_q    <= s3_day_q + DW'(day_fix_d);
      s4_tod_q    <= {rem_fix_d[9:0], s3_lo_q};
      s5_dp_q     <= PW'(s4_day_q) + PW'(Days1601To1970);
      s5_hprod_q  <= 23'(s4_tod_q) * 23'(RecipHour);
      s5_tod_q    <= s4_tod_q;
      s6_cprod_q  <= CW'(s5_dp_q) * CW'(RecipCycle);
      s6_dp_q     <= s5_dp_q;
      s6_hest_q   <= hest_d;
      s6_rh_q     <= s5_tod_q[12:0] - 13'(hest_d) * 13'(SecsPerHour);
      s7_n400_q   <= nest_d;
      s7_r400_q   <= 19'(s6_dp_q) - 19'(nest_d) * 19'(DaysPer400);
      s7_rh_q     <= 12'(hfix_d ? s6_rh_q - 13'(SecsPerHour) : s6_rh_q);
      s8_r400_q   <= r400_d;
      s8_mprod_q  <= 19'(s7_rh_q) * 19'(RecipMin);
      s8_rhlo_q   <= s7_rh_q[6:0];
      s9_r100_q   <= r100_d;
      s9_mest_q   <= mest_d;
      s9_sraw_q   <= s8_rhlo_q - mest_d * 7'(SecsPerMinute);
      s10_prod4_q <= 22'(s9_r100_q) * 22'(RecipQuad);
      s10_r100_q  <= s9_r100_q;
      s11_n4_q    <= n4est_d;
      s11_r4_q    <= s10_r100_q[11:0] - 12'(n4est_d) * 12'(DaysPer4);
      s12_r4_q    <= 11'(qfix_d ? s11_r4_q - 12'(DaysPer4) : s11_r4_q);
    end
  end

  assign out_valid_o    = vld_q[NumStages-1];
  assign second_o       = res_q[NumStages-1].second;
  assign minute_o       = res_q[NumStages-1].minute;
  assign hour_o         = res_q[NumStages-1].hour;
  assign year_o         = res_q[NumStages-1].year;
  assign day_of_year_o  = res_q[NumStages-1].doy;
  assign month_index_o  = res_q[NumStages-1].month;
  assign day_of_month_o = res_q[NumStages-1].dom;
  assign weekday_o      = res_q[NumStages-1].weekday;

`ifndef SYNTHESIS
  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (second_o < 6'd60) && (minute_o < 6'd60) && (hour_o < 5'd24))
    else $error("time of day field out of range");

  a_date_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_index_o <= 4'd11) && (day_of_month_o != 5'd0)
                    && (weekday_o <= 3'd6) && (day_of_year_o <= 9'd365))
    else $error("date field out of range");

  a_last_day_leap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (day_of_year_o == 9'd365) |-> res_q[NumStages-1].leap)
    else $error("day 365 in a common year");

  a_dec_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (month_index_o == 4'd11) |->
      (day_of_year_o == 9'(9'd333 + 9'(res_q[NumStages-1].leap) + 9'(day_of_month_o))))
    else $error("December day does not match day of year");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");
`endif

endmodule
